### sv/windowed_rms_audio_correlation_assert.svh
// Assertion macros for the windowed RMS correlation block.
`ifndef WINDOWED_RMS_AUDIO_CORRELATION_ASSERT_SVH
`define WINDOWED_RMS_AUDIO_CORRELATION_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define WRAC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wrac: assertion failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define WRAC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wrac: assertion failed");

`endif

### sv/wrac_pkg.sv
// Shared constants, types and helpers of the windowed RMS correlation block.
package wrac_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int WINDOW_BITS = 16;

    localparam int SUM_W   = 47;   // per-window square sum
    localparam int MS_W    = 48;   // mean square, Q30.16 with headroom
    localparam int RMS_W   = 32;   // RMS, Q16.16
    localparam int TOT_W   = 64;   // running totals
    localparam int CORR_W  = 17;   // Q1.16 result
    localparam int NUM_W   = 128;  // shared unit numerator
    localparam int REM_W   = 68;   // shared unit partial remainder
    localparam int STEP_W  = 7;    // shared unit step count

    localparam int MS_DIV_STEPS   = SUM_W + FRAC_BITS;            // 63
    localparam int RMS_SQ_STEPS   = (MS_W + FRAC_BITS) / 2;       // 32
    localparam int DEN_SQ_STEPS   = NUM_W / 2;                    // 64
    localparam int CORR_DIV_STEPS = TOT_W + FRAC_BITS;            // 80

    localparam logic [CORR_W-1:0] CORR_ONE = CORR_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic              start;
        logic              sqrt_mode;
        logic [STEP_W-1:0] steps;
    } wrac_unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wrac_unit_stat_t;

    // Magnitude of the mono mix (left + right) / 2, truncated toward zero.
    function automatic logic [SAMPLE_BITS-1:0] mono_abs(
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r
    );
        logic signed [SAMPLE_BITS:0] s;
        logic signed [SAMPLE_BITS:0] m;
        logic        [SAMPLE_BITS:0] a;
        s = $signed({l[SAMPLE_BITS-1], l}) + $signed({r[SAMPLE_BITS-1], r});
        m = (s + $signed({{SAMPLE_BITS{1'b0}}, s[SAMPLE_BITS]})) >>> 1;
        a = m[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-m) : m;
        return a[SAMPLE_BITS-1:0];
    endfunction

endpackage

### sv/windowed_rms_audio_correlation.sv
// Frame item: squares both mono mixes into the window sums. Window close: two 63-step divides, two 32-step roots.
// Finish item: window close if partial, 64x64 product, 64-step root, 80-step divide unless denom is 0 or <= numerator.
// All iteration runs through one shared shift-subtract unit; s_ready is low meanwhile.
// The result waits in an output register; the next finish result holds in ST_EMIT until it is taken.
// Synchronous active-low reset clears totals, flags and sets window_size to 1024.
module windowed_rms_audio_correlation import wrac_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [WINDOW_BITS-1:0]        cfg_window_size,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic signed [SAMPLE_BITS-1:0] s_left_a,
    input  logic signed [SAMPLE_BITS-1:0] s_right_a,
    input  logic signed [SAMPLE_BITS-1:0] s_left_b,
    input  logic signed [SAMPLE_BITS-1:0] s_right_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [CORR_W-1:0]             m_correlation,
    output logic                          m_undefined_result,
    output logic                          m_saturated
);

`include "windowed_rms_audio_correlation_assert.svh"

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ_A  = 4'd1;
    localparam logic [3:0] ST_SQ_B  = 4'd2;
    localparam logic [3:0] ST_ACC_B = 4'd3;
    localparam logic [3:0] ST_MS_A  = 4'd4;
    localparam logic [3:0] ST_MS_B  = 4'd5;
    localparam logic [3:0] ST_RMS_A = 4'd6;
    localparam logic [3:0] ST_RMS_B = 4'd7;
    localparam logic [3:0] ST_PROD  = 4'd8;
    localparam logic [3:0] ST_TOT   = 4'd9;
    localparam logic [3:0] ST_PP    = 4'd10;
    localparam logic [3:0] ST_DEN   = 4'd11;
    localparam logic [3:0] ST_CORR  = 4'd12;
    localparam logic [3:0] ST_CDIV  = 4'd13;
    localparam logic [3:0] ST_EMIT  = 4'd14;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(1024);

    logic [3:0]             state_reg, state_next;
    logic [WINDOW_BITS-1:0] window_size_reg;
    logic                   finish_reg;
    logic [SAMPLE_BITS-1:0] abs_a_reg, abs_b_reg;
    logic [2*RMS_W-1:0]     mul_reg;
    logic [WINDOW_BITS-1:0] frames_reg;
    logic [SUM_W-1:0]       sum_a_reg, sum_b_reg;
    logic [TOT_W-1:0]       tot_a_reg, tot_b_reg, rpt_reg;
    logic                   sat_reg;
    logic [MS_W-1:0]        ms_a_reg, ms_b_reg;
    logic [RMS_W-1:0]       rms_a_reg, rms_b_reg;
    logic [2:0]             pp_cnt_reg;
    logic [NUM_W-1:0]       den_acc_reg;
    logic [TOT_W-1:0]       denom_reg;
    logic                   run_reg;
    logic [CORR_W-1:0]      corr_reg;
    logic                   undef_reg;
    logic                   m_valid_reg;
    logic [CORR_W-1:0]      m_corr_reg;
    logic                   m_undef_reg;
    logic                   m_sat_reg;

    logic [RMS_W-1:0]       mul_x, mul_y;
    logic [1:0]             pp_k;
    logic [1:0]             acc_k;
    logic [WINDOW_BITS:0]   frames_inc;
    logic [WINDOW_BITS:0]   limit;
    logic                   unit_state;
    wrac_unit_req_t         unit_req;
    wrac_unit_stat_t        unit_stat;
    logic [NUM_W-1:0]       unit_numer;
    logic [TOT_W-1:0]       unit_divisor;
    logic [TOT_W-1:0]       unit_result;
    logic [TOT_W:0]         add_a, add_b, add_p;
    logic                   in_fire;
    logic                   emit_fire;

    wrac_root_div u_root_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .numer   (unit_numer),
        .divisor (unit_divisor),
        .stat    (unit_stat),
        .result  (unit_result)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign frames_inc = {1'b0, frames_reg} + (WINDOW_BITS+1)'(1);
    assign limit      = (window_size_reg == '0) ? (WINDOW_BITS+1)'(1)
                                                : {1'b0, window_size_reg};

    assign pp_k  = pp_cnt_reg[1:0];
    assign acc_k = pp_k - 2'd1;

    // Shared 32x32 multiplier operand select.
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (state_reg)
            ST_SQ_A: begin
                mul_x = RMS_W'(abs_a_reg);
                mul_y = RMS_W'(abs_a_reg);
            end
            ST_SQ_B: begin
                mul_x = RMS_W'(abs_b_reg);
                mul_y = RMS_W'(abs_b_reg);
            end
            ST_PROD: begin
                mul_x = rms_a_reg;
                mul_y = rms_b_reg;
            end
            ST_PP: begin
                mul_x = pp_k[1] ? tot_a_reg[TOT_W-1:RMS_W] : tot_a_reg[RMS_W-1:0];
                mul_y = pp_k[0] ? tot_b_reg[TOT_W-1:RMS_W] : tot_b_reg[RMS_W-1:0];
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // Shared unit operand select.
    always_comb begin
        unit_state          = 1'b1;
        unit_req.sqrt_mode  = 1'b0;
        unit_req.steps      = STEP_W'(MS_DIV_STEPS);
        unit_numer          = '0;
        unit_divisor        = '0;
        unique case (state_reg)
            ST_MS_A: begin
                unit_numer   = {sum_a_reg, {(NUM_W-SUM_W){1'b0}}};
                unit_divisor = TOT_W'(frames_reg);
            end
            ST_MS_B: begin
                unit_numer   = {sum_b_reg, {(NUM_W-SUM_W){1'b0}}};
                unit_divisor = TOT_W'(frames_reg);
            end
            ST_RMS_A: begin
                unit_req.sqrt_mode = 1'b1;
                unit_req.steps     = STEP_W'(RMS_SQ_STEPS);
                unit_numer         = {ms_a_reg, {(NUM_W-MS_W){1'b0}}};
            end
            ST_RMS_B: begin
                unit_req.sqrt_mode = 1'b1;
                unit_req.steps     = STEP_W'(RMS_SQ_STEPS);
                unit_numer         = {ms_b_reg, {(NUM_W-MS_W){1'b0}}};
            end
            ST_DEN: begin
                unit_req.sqrt_mode = 1'b1;
                unit_req.steps     = STEP_W'(DEN_SQ_STEPS);
                unit_numer         = den_acc_reg;
            end
            ST_CDIV: begin
                unit_req.steps = STEP_W'(CORR_DIV_STEPS);
                unit_numer     = {rpt_reg, {(NUM_W-TOT_W){1'b0}}};
                unit_divisor   = denom_reg;
            end
            default: unit_state = 1'b0;
        endcase
        unit_req.start = unit_state && !run_reg;
    end

    assign add_a = {1'b0, tot_a_reg} + (TOT_W+1)'(ms_a_reg);
    assign add_b = {1'b0, tot_b_reg} + (TOT_W+1)'(ms_b_reg);
    assign add_p = {1'b0, rpt_reg} + (TOT_W+1)'(mul_reg[2*RMS_W-1:FRAC_BITS]);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!s_req_type)               state_next = ST_SQ_A;
                    else if (frames_reg != '0)     state_next = ST_MS_A;
                    else                           state_next = ST_PP;
                end
            end
            ST_SQ_A:  state_next = ST_SQ_B;
            ST_SQ_B:  state_next = ST_ACC_B;
            ST_ACC_B: state_next = (frames_inc >= limit) ? ST_MS_A : ST_IDLE;
            ST_MS_A:  if (run_reg && unit_stat.done) state_next = ST_MS_B;
            ST_MS_B:  if (run_reg && unit_stat.done) state_next = ST_RMS_A;
            ST_RMS_A: if (run_reg && unit_stat.done) state_next = ST_RMS_B;
            ST_RMS_B: if (run_reg && unit_stat.done) state_next = ST_PROD;
            ST_PROD:  state_next = ST_TOT;
            ST_TOT:   state_next = finish_reg ? ST_PP : ST_IDLE;
            ST_PP:    if (pp_cnt_reg == 3'd4) state_next = ST_DEN;
            ST_DEN:   if (run_reg && unit_stat.done) state_next = ST_CORR;
            ST_CORR: begin
                if (denom_reg == '0 || rpt_reg >= denom_reg) state_next = ST_EMIT;
                else                                         state_next = ST_CDIV;
            end
            ST_CDIV:  if (run_reg && unit_stat.done) state_next = ST_EMIT;
            ST_EMIT:  if (emit_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            window_size_reg <= WINDOW_RESET;
            finish_reg      <= 1'b0;
            frames_reg      <= '0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            tot_a_reg       <= '0;
            tot_b_reg       <= '0;
            rpt_reg         <= '0;
            sat_reg         <= 1'b0;
            pp_cnt_reg      <= '0;
            run_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            mul_reg   <= mul_x * mul_y;

            if (cfg_valid && cfg_ready) window_size_reg <= cfg_window_size;

            // Track the shared unit launch and completion.
            if (unit_req.start)                   run_reg <= 1'b1;
            else if (run_reg && unit_stat.done)   run_reg <= 1'b0;

            if (m_valid_reg && m_ready && !emit_fire) m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        finish_reg  <= s_req_type;
                        abs_a_reg   <= mono_abs(s_left_a, s_right_a);
                        abs_b_reg   <= mono_abs(s_left_b, s_right_b);
                        pp_cnt_reg  <= '0;
                        den_acc_reg <= '0;
                    end
                end
                ST_SQ_B:  sum_a_reg <= sum_a_reg + SUM_W'(mul_reg);
                ST_ACC_B: begin
                    sum_b_reg  <= sum_b_reg + SUM_W'(mul_reg);
                    frames_reg <= frames_inc[WINDOW_BITS-1:0];
                end
                ST_MS_A:  if (run_reg && unit_stat.done) ms_a_reg <= unit_result[MS_W-1:0];
                ST_MS_B:  if (run_reg && unit_stat.done) ms_b_reg <= unit_result[MS_W-1:0];
                ST_RMS_A: if (run_reg && unit_stat.done) rms_a_reg <= unit_result[RMS_W-1:0];
                ST_RMS_B: if (run_reg && unit_stat.done) rms_b_reg <= unit_result[RMS_W-1:0];
                ST_TOT: begin
                    // Add window results to the totals, saturating.
                    tot_a_reg <= add_a[TOT_W] ? '1 : add_a[TOT_W-1:0];
                    tot_b_reg <= add_b[TOT_W] ? '1 : add_b[TOT_W-1:0];
                    rpt_reg   <= add_p[TOT_W] ? '1 : add_p[TOT_W-1:0];
                    if (add_a[TOT_W] || add_b[TOT_W] || add_p[TOT_W]) sat_reg <= 1'b1;
                    frames_reg  <= '0;
                    sum_a_reg   <= '0;
                    sum_b_reg   <= '0;
                    pp_cnt_reg  <= '0;
                    den_acc_reg <= '0;
                end
                ST_PP: begin
                    // Accumulate the previous cycle's partial product.
                    pp_cnt_reg <= pp_cnt_reg + 3'd1;
                    if (pp_cnt_reg != 3'd0) begin
                        den_acc_reg <= den_acc_reg +
                            (NUM_W'(mul_reg) << {acc_k[1] & acc_k[0], acc_k[1] ^ acc_k[0], 5'b0});
                    end
                end
                ST_DEN:   if (run_reg && unit_stat.done) denom_reg <= unit_result;
                ST_CORR: begin
                    undef_reg <= (denom_reg == '0);
                    if (denom_reg == '0)          corr_reg <= '0;
                    else if (rpt_reg >= denom_reg) corr_reg <= CORR_ONE;
                end
                ST_CDIV:  if (run_reg && unit_stat.done) corr_reg <= unit_result[CORR_W-1:0];
                ST_EMIT: begin
                    if (emit_fire) begin
                        m_valid_reg <= 1'b1;
                        m_corr_reg  <= corr_reg;
                        m_undef_reg <= undef_reg;
                        m_sat_reg   <= sat_reg;
                        tot_a_reg   <= '0;
                        tot_b_reg   <= '0;
                        rpt_reg     <= '0;
                        sat_reg     <= 1'b0;
                        frames_reg  <= '0;
                        sum_a_reg   <= '0;
                        sum_b_reg   <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_correlation      = m_corr_reg;
    assign m_undefined_result = m_undef_reg;
    assign m_saturated        = m_sat_reg;

    `WRAC_ASSERT_NXT(a_busy_after_accept, in_fire, !s_ready)
    `WRAC_ASSERT_IMP(a_unit_start_idle, unit_req.start, !unit_stat.busy)
    `WRAC_ASSERT_IMP(a_undef_zero, m_valid && m_undefined_result, m_correlation == '0)

endmodule

### sv/wrac_root_div.sv
// Shared shift-subtract unit: restoring division or square root, one digit per cycle.
module wrac_root_div import wrac_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wrac_unit_req_t       req,
    input  logic [NUM_W-1:0]     numer,
    input  logic [TOT_W-1:0]     divisor,
    output wrac_unit_stat_t      stat,
    output logic [TOT_W-1:0]     result
);

    logic [NUM_W-1:0]  num_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [TOT_W-1:0]  res_reg;
    logic [TOT_W-1:0]  div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              sqrt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    always_comb begin
        if (sqrt_reg) begin
            rem_sh = {rem_reg[REM_W-3:0], num_reg[NUM_W-1 -: 2]};
            trial  = {2'b00, res_reg, 2'b01};
        end else begin
            rem_sh = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
            trial  = {{(REM_W-TOT_W){1'b0}}, div_reg};
        end
        take = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // Pulse done on the last step.
            done_reg <= !req.start && busy_reg && (cnt_reg == STEP_W'(1));
            if (req.start) begin
                num_reg  <= numer;
                div_reg  <= divisor;
                rem_reg  <= '0;
                res_reg  <= '0;
                sqrt_reg <= req.sqrt_mode;
                cnt_reg  <= req.steps;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= take ? (rem_sh - trial) : rem_sh;
                res_reg <= {res_reg[TOT_W-2:0], take};
                num_reg <= sqrt_reg ? (num_reg << 2) : (num_reg << 1);
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule

### bench/tb_windowed_rms_audio_correlation.sv
// Self-checking testbench for the windowed RMS correlation block.
`timescale 1ns / 100ps

module tb_windowed_rms_audio_correlation;
    import wrac_pkg::*;

    localparam logic REQ_FRAME  = 1'b0;
    localparam logic REQ_FINISH = 1'b1;
    localparam int   SETTLE     = 800;   // window close plus finish, with margin
    localparam logic [63:0] TOP = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {ROW_FRAME, ROW_FINISH, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        logic signed [SAMPLE_BITS-1:0] la, ra, lb, rb;
        logic [WINDOW_BITS-1:0]        wsize;
        bit                            typed;
        logic [CORR_W-1:0]             corr;
        logic                          undef;
        logic                          sat;
    } row_t;

    typedef struct {
        logic [CORR_W-1:0] corr;
        logic              undef;
        logic              sat;
    } corr_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [WINDOW_BITS-1:0] cfg_window_size = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = REQ_FRAME;
    logic signed [SAMPLE_BITS-1:0] s_left_a = '0, s_right_a = '0;
    logic signed [SAMPLE_BITS-1:0] s_left_b = '0, s_right_b = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CORR_W-1:0] m_correlation;
    logic m_undefined_result;
    logic m_saturated;

    // predictor state
    logic [WINDOW_BITS-1:0] win_len;
    logic [16:0]            fill;
    logic [63:0]            sq_a, sq_b, ms_tot_a, ms_tot_b, rms_prod_tot;
    bit                     sat_seen;

    corr_result_t expected_q[$];
    row_t         plan[$];
    int  mismatches = 0, n_frames = 0, n_finishes = 0, n_writes = 0;
    int  n_results = 0, n_undef = 0;
    int  hold_cycles = 0;
    bit  rx_burst = 0, tx_burst = 0;

    windowed_rms_audio_correlation u_dut (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_window_size,
        .s_valid, .s_ready, .s_req_type, .s_left_a, .s_right_a, .s_left_b, .s_right_b,
        .m_valid, .m_ready, .m_correlation, .m_undefined_result, .m_saturated
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results pending", expected_q.size());
        $display("windowed_rms_audio_correlation: mismatch");
        $finish;
    end

    function automatic logic [63:0] root128(input logic [127:0] x);
        logic [63:0] r, c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= x) r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] div_clip(input logic [127:0] num, input logic [63:0] d,
                                             output bit clipped);
        logic [127:0] q;
        clipped = 0;
        if (num[127:64] >= d) begin
            clipped = 1;
            return TOP;
        end
        q = num / {64'd0, d};
        return q[63:0];
    endfunction

    function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            sat_seen = 1;
            return TOP;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] mono_sq(input logic signed [SAMPLE_BITS-1:0] l,
                                            input logic signed [SAMPLE_BITS-1:0] r);
        int m;
        m = (int'(l) + int'(r)) / 2;
        if (m < 0) m = -m;
        return 64'(m) * 64'(m);
    endfunction

    task automatic close_window();
        logic [63:0]  ms_a, ms_b, rms_a, rms_b, prod;
        logic [127:0] p;
        bit           c;
        if (fill == 0) return;
        ms_a = div_clip({64'd0, sq_a} << FRAC_BITS, 64'(fill), c);
        if (c) sat_seen = 1;
        ms_b = div_clip({64'd0, sq_b} << FRAC_BITS, 64'(fill), c);
        if (c) sat_seen = 1;
        rms_a = root128({64'd0, ms_a} << FRAC_BITS);
        rms_b = root128({64'd0, ms_b} << FRAC_BITS);
        p = {64'd0, rms_a} * {64'd0, rms_b};
        if (p[127:64+FRAC_BITS] != 0) begin
            prod = TOP;
            sat_seen = 1;
        end else begin
            prod = p[63+FRAC_BITS:FRAC_BITS];
        end
        ms_tot_a     = add_clip(ms_tot_a, ms_a);
        ms_tot_b     = add_clip(ms_tot_b, ms_b);
        rms_prod_tot = add_clip(rms_prod_tot, prod);
        fill = 0;
        sq_a = 0;
        sq_b = 0;
    endtask

    task automatic clear_totals();
        fill = 0; sq_a = 0; sq_b = 0;
        ms_tot_a = 0; ms_tot_b = 0; rms_prod_tot = 0;
        sat_seen = 0;
    endtask

    // Advance the predictor by one item; sets has to 1 when the item yields a result.
    task automatic predict_correlation(input row_t it, output bit has, output corr_result_t res);
        logic [16:0] limit;
        logic [63:0] den, q;
        bit          c;
        has = 0;
        res = '{default: '0};
        limit = (win_len == 0) ? 17'd1 : 17'(win_len);
        if (it.kind == ROW_FRAME) begin
            sq_a = add_clip(sq_a, mono_sq(it.la, it.ra));
            sq_b = add_clip(sq_b, mono_sq(it.lb, it.rb));
            fill = fill + 1'b1;
            if (fill >= limit) close_window();
            return;
        end
        close_window();
        den = root128({64'd0, ms_tot_a} * {64'd0, ms_tot_b});
        if (den == 0) begin
            res.undef = 1;
        end else if (rms_prod_tot >= den) begin
            res.corr = CORR_ONE;
        end else begin
            q = div_clip({64'd0, rms_prod_tot} << FRAC_BITS, den, c);
            res.corr = (q > 64'(CORR_ONE)) ? CORR_ONE : q[CORR_W-1:0];
        end
        res.sat = sat_seen;
        clear_totals();
        has = 1;
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // Write the window size; waits until nothing is outstanding and the block has settled.
    task automatic write_window(input logic [WINDOW_BITS-1:0] w);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_window_size = w;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        win_len = w;
        n_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_item(input row_t it);
        int           gap;
        bit           has;
        corr_result_t res;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type = (it.kind == ROW_FINISH) ? REQ_FINISH : REQ_FRAME;
        s_left_a   = it.la;
        s_right_a  = it.ra;
        s_left_b   = it.lb;
        s_right_b  = it.rb;
        s_valid    = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_correlation(it, has, res);
        if (it.kind == ROW_FINISH) n_finishes++; else n_frames++;
        if (has) begin
            if (it.typed) begin
                res.corr  = it.corr;
                res.undef = it.undef;
                res.sat   = it.sat;
            end
            expected_q.push_back(res);
        end
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic run_row(input row_t it);
        if (it.kind == ROW_CFG) begin
            s_valid = 1'b0;
            write_window(it.wsize);
        end else begin
            send_item(it);
        end
    endtask

    function automatic row_t mk(input row_kind_t k, input int la, input int ra,
                                input int lb, input int rb);
        row_t r;
        r = '{kind: k, default: '0};
        r.la = la[15:0]; r.ra = ra[15:0]; r.lb = lb[15:0]; r.rb = rb[15:0];
        r.wsize = la[15:0];
        return r;
    endfunction

    function automatic row_t mk_undef();
        row_t r;
        r = mk(ROW_FINISH, -1, 12345, -32768, 7);
        r.typed = 1;
        r.undef = 1;
        return r;
    endfunction

    function automatic int draw_sample(input int mode);
        case (mode)
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 64) - 32;
            2: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: return $urandom_range(0, 8000) - 4000;
        endcase
    endfunction

    function automatic row_t random_frame(input int mode);
        row_t r;
        int   la, ra;
        la = draw_sample(mode);
        ra = draw_sample(mode);
        case ($urandom_range(0, 5))
            0: r = mk(ROW_FRAME, la, ra, la, ra);
            1: r = mk(ROW_FRAME, la, ra, -la, -ra);
            2: r = mk(ROW_FRAME, la, ra, la / 2, ra / 3);
            3: r = mk(ROW_FRAME, 0, 0, la, ra);
            default: r = mk(ROW_FRAME, la, ra, draw_sample(mode), draw_sample(mode));
        endcase
        return r;
    endfunction

    // receiver
    initial begin
        int           stall;
        corr_result_t want;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            n_results++;
            if (m_undefined_result) n_undef++;
            if (expected_q.size() == 0) begin
                report("unexpected result, correlation", 64'(m_correlation), 64'd0);
            end else begin
                want = expected_q.pop_front();
                if (m_correlation !== want.corr)
                    report("correlation", 64'(m_correlation), 64'(want.corr));
                if (m_undefined_result !== want.undef)
                    report("undefined_result", 64'(m_undefined_result), 64'(want.undef));
                if (m_saturated !== want.sat)
                    report("saturated", 64'(m_saturated), 64'(want.sat));
            end
            @(negedge aclk);
        end
    end

    // stimulus
    initial begin
        row_t r;
        int   mode, nf;
        win_len = 16'd1024;
        clear_totals();

        r = mk_undef();
        plan.push_back(r);                               // nothing seen since reset
        plan.push_back(mk(ROW_CFG, 1, 0, 0, 0));
        plan.push_back(mk(ROW_FRAME, 32767, 32767, 32767, 32767));
        plan.push_back(mk(ROW_FRAME, -32768, -32768, -32768, -32768));
        plan.push_back(mk(ROW_FINISH, 0, 0, 0, 0));
        plan.push_back(mk(ROW_FRAME, 0, 0, 5, 7));       // stream A silent
        plan.push_back(mk_undef());
        plan.push_back(mk(ROW_FRAME, 32767, -32768, -1, 0)); // both mix to zero
        plan.push_back(mk_undef());
        plan.push_back(mk(ROW_FRAME, -3, 0, -32768, 32767));
        plan.push_back(mk(ROW_FRAME, 100, -50, -100, 50));
        plan.push_back(mk(ROW_FINISH, 0, 0, 0, 0));
        plan.push_back(mk(ROW_CFG, 0, 0, 0, 0));          // zero size acts as one
        plan.push_back(mk(ROW_FRAME, 1000, -1000, 3, 9));
        plan.push_back(mk(ROW_FRAME, -20000, 7, 32767, 32767));
        plan.push_back(mk(ROW_FINISH, 0, 0, 0, 0));
        plan.push_back(mk(ROW_CFG, 65535, 0, 0, 0));
        plan.push_back(mk(ROW_FRAME, 1234, 4321, -777, 888));
        plan.push_back(mk(ROW_FRAME, -32768, 32767, 32767, -32768));
        plan.push_back(mk(ROW_FINISH, -1, -1, -1, -1));   // partial window closed
        plan.push_back(mk(ROW_CFG, 8, 0, 0, 0));
        for (int i = 0; i < 5; i++) plan.push_back(mk(ROW_FRAME, 300 * i, 11, -9, 500));
        plan.push_back(mk(ROW_CFG, 3, 0, 0, 0));          // shrink below current fill
        plan.push_back(mk(ROW_FRAME, 77, 78, 79, -80));
        plan.push_back(mk(ROW_FINISH, 0, 0, 0, 0));
        plan.push_back(mk_undef());                      // back-to-back finish

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (plan[i]) run_row(plan[i]);

        // long receiver hold while finishes keep coming
        write_window(16'd1);
        hold_cycles = 3000;
        for (int i = 0; i < 12; i++) begin
            send_item(random_frame(0));
            send_item(mk(ROW_FINISH, 0, 0, 0, 0));
        end

        while (n_frames + n_finishes < 1100) begin
            case ($urandom_range(0, 9))
                0: write_window(16'd0);
                1: write_window(16'hFFFF);
                2: write_window(16'($urandom_range(9, 40)));
                3: write_window(16'($urandom));
                default: write_window(16'($urandom_range(1, 8)));
            endcase
            rx_burst = ($urandom_range(0, 3) == 0);
            tx_burst = ($urandom_range(0, 3) == 0);
            for (int ph = 0; ph < 4; ph++) begin
                mode = $urandom_range(0, 3);
                nf = $urandom_range(0, 14);
                for (int k = 0; k < nf; k++) send_item(random_frame(mode));
                send_item(mk(ROW_FINISH, draw_sample(0), draw_sample(0),
                             draw_sample(0), draw_sample(0)));
            end
        end
        s_valid = 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        $display("covered %0d frame items, %0d finish items, %0d window writes",
                 n_frames, n_finishes, n_writes);
        $display("checked %0d results (%0d undefined), %0d mismatches",
                 n_results, n_undef, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("windowed_rms_audio_correlation: match");
        else
            $display("windowed_rms_audio_correlation: mismatch");
        $finish;
    end

endmodule
